// ===== hw/rtl/epb_pkg.sv =====
package epb_pkg;

    localparam int unsigned PALETTE_ENTRIES = 256;
    localparam int unsigned COLOR_W         = 32;
    localparam int unsigned IDX_W           = 8;
    localparam int unsigned CNT_W           = 9;
    localparam int unsigned GROUP_CELLS     = 16;

    typedef logic [COLOR_W-1:0] t_color;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_RED  = 4'b0100,
        S_WB   = 4'b1000
    } t_state;

    typedef struct packed {
        logic   cmp_en;
        logic   wr_en;
        t_color key;
        t_cnt   count;
        t_idx   new_index;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/epb_cell.sv =====
module epb_cell #(
    parameter int unsigned POS = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  epb_pkg::t_cell_ctl i_ctl,
    input  logic               i_prev_gt,
    input  epb_pkg::t_color    i_prev_color,
    input  epb_pkg::t_idx      i_prev_index,
    output logic               o_gt,
    output logic               o_match,
    output epb_pkg::t_color    o_color,
    output epb_pkg::t_idx      o_index
);
    import epb_pkg::*;

    logic   r_gt;
    logic   r_match;
    t_color r_color;
    t_idx   r_index;
    logic   in_use;
    logic   is_tail;

    assign in_use  = CNT_W'(POS) < i_ctl.count;
    assign is_tail = CNT_W'(POS) == i_ctl.count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gt    <= 1'b0;
            r_match <= 1'b0;
        end else if (i_ctl.cmp_en) begin
            r_gt    <= in_use && (r_color > i_ctl.key);
            r_match <= in_use && (r_color == i_ctl.key);
        end
    end

    // shift right behind the insert point, take the new word at it
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            if (i_prev_gt) begin
                r_color <= i_prev_color;
                r_index <= i_prev_index;
            end else if (r_gt || is_tail) begin
                r_color <= i_ctl.key;
                r_index <= i_ctl.new_index;
            end
        end
    end

    assign o_gt    = r_gt;
    assign o_match = r_match;
    assign o_color = r_color;
    assign o_index = r_index;

endmodule

// ===== hw/rtl/epb_group.sv =====
module epb_group #(
    parameter int unsigned CELLS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [CELLS-1:0]              i_match,
    input  logic [CELLS-1:0][epb_pkg::IDX_W-1:0] i_index,
    output logic                          o_found,
    output epb_pkg::t_idx                 o_index
);
    import epb_pkg::*;

    logic r_found;
    t_idx r_index;
    t_idx n_index;

    always_comb begin
        n_index = '0;
        for (int c = 0; c < CELLS; c++) begin
            n_index = n_index | (i_index[c] & {IDX_W{i_match[c]}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_en) begin
            r_found <= |i_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_index <= n_index;
        end
    end

    assign o_found = r_found;
    assign o_index = r_index;

endmodule

// ===== hw/rtl/exact_color_palette_builder_unit.sv =====
// channel | direction | handshake          | words
// pixel   | in        | i_valid / o_stall  | i_pixel_color, i_last_pixel
// result  | out       | o_valid / i_stall  | o_palette_index, o_new_entry, o_entry_color,
//         |           |                    | o_overflow, o_image_done
//
// Each pixel goes through accept, compare in every cell, registered group reduction
// of the match flags, then the write-back, which shifts the cell chain on an insert.
// One pixel is in flight at a time; o_stall is high from accept until write-back.
// Write-back waits while a finished result is held and i_stall is high.
// Synchronous reset clears the entry count, overflow flag and result valid;
// the cell contents are read only below the entry count and need no clearing.
module exact_color_palette_builder_unit #(
    parameter int unsigned PALETTE_ENTRIES = epb_pkg::PALETTE_ENTRIES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [31:0]           i_pixel_color,
    input  logic                  i_last_pixel,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_palette_index,
    output logic                  o_new_entry,
    output logic [31:0]           o_entry_color,
    output logic                  o_overflow,
    output logic                  o_image_done
);
    import epb_pkg::*;

    localparam int unsigned CW = $clog2(PALETTE_ENTRIES + 1);
    localparam int unsigned NG = (PALETTE_ENTRIES + GROUP_CELLS - 1) / GROUP_CELLS;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic            r_overflow;
    t_color          r_key;
    logic            r_last;

    logic            r_out_valid;
    t_idx            r_out_index;
    logic            r_out_new;
    t_color          r_out_color;
    logic            r_out_ovf;
    logic            r_out_done;

    t_cell_ctl       ctl;
    logic [PALETTE_ENTRIES-1:0]            w_gt;
    logic [PALETTE_ENTRIES-1:0]            w_match;
    logic [PALETTE_ENTRIES-1:0][COLOR_W-1:0] w_color;
    logic [PALETTE_ENTRIES-1:0][IDX_W-1:0] w_index;
    logic [NG-1:0]                         g_found;
    logic [NG-1:0][IDX_W-1:0]              g_index;

    logic            accept;
    logic            wb_go;
    logic            found;
    t_idx            found_index;
    logic            full;
    logic            insert;
    logic            n_ovf;

    assign accept = r_state == S_IDLE && i_valid;
    assign wb_go  = r_state == S_WB && (!r_out_valid || !i_stall);
    assign full   = r_count == CW'(PALETTE_ENTRIES);

    always_comb begin
        found       = 1'b0;
        found_index = '0;
        for (int g = 0; g < NG; g++) begin
            found       = found | g_found[g];
            found_index = found_index | (g_index[g] & {IDX_W{g_found[g]}});
        end
    end

    assign insert = !found && !full;
    assign n_ovf  = r_overflow || (!found && full);

    assign ctl.cmp_en    = r_state == S_CMP;
    assign ctl.wr_en     = wb_go && insert;
    assign ctl.key       = r_key;
    assign ctl.count     = CNT_W'(r_count);
    assign ctl.new_index = IDX_W'(r_count);

    generate
        for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
            logic   prev_gt;
            t_color prev_color;
            t_idx   prev_index;
            if (i == 0) begin : g_head
                assign prev_gt    = 1'b0;
                assign prev_color = '0;
                assign prev_index = '0;
            end else begin : g_link
                assign prev_gt    = w_gt[i-1];
                assign prev_color = w_color[i-1];
                assign prev_index = w_index[i-1];
            end
            epb_cell #(
                .POS(i)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (ctl),
                .i_prev_gt    (prev_gt),
                .i_prev_color (prev_color),
                .i_prev_index (prev_index),
                .o_gt         (w_gt[i]),
                .o_match      (w_match[i]),
                .o_color      (w_color[i]),
                .o_index      (w_index[i])
            );
        end

        for (genvar g = 0; g < NG; g++) begin : g_grp
            localparam int unsigned LO = g * GROUP_CELLS;
            localparam int unsigned GW = (PALETTE_ENTRIES - LO < GROUP_CELLS) ?
                                         PALETTE_ENTRIES - LO : GROUP_CELLS;
            epb_group #(
                .CELLS(GW)
            ) u_group (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (r_state == S_RED),
                .i_match (w_match[LO +: GW]),
                .i_index (w_index[LO +: GW]),
                .o_found (g_found[g]),
                .o_index (g_index[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_RED;
                end
                S_RED: begin
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (wb_go) begin
                        r_state <= S_IDLE;
                        if (r_last) begin
                            r_count    <= '0;
                            r_overflow <= 1'b0;
                        end else begin
                            r_count    <= r_count + CW'(insert);
                            r_overflow <= n_ovf;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key  <= i_pixel_color;
            r_last <= i_last_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (wb_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb_go) begin
            r_out_index <= found ? found_index : (insert ? IDX_W'(r_count) : '0);
            r_out_new   <= insert;
            r_out_color <= insert ? r_key : '0;
            r_out_ovf   <= n_ovf;
            r_out_done  <= r_last;
        end
    end

    assign o_stall         = r_state != S_IDLE;
    assign o_valid         = r_out_valid;
    assign o_palette_index = r_out_index;
    assign o_new_entry     = r_out_new;
    assign o_entry_color   = r_out_color;
    assign o_overflow      = r_out_ovf;
    assign o_image_done    = r_out_done;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(PALETTE_ENTRIES))
        else $error("entry count above capacity");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> full)
        else $error("overflow set with free entries");

    a_new_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_new_entry) |-> !o_overflow)
        else $error("new entry reported together with overflow");

    a_color_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_new_entry) |-> (o_entry_color == '0))
        else $error("entry color nonzero without new entry");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("pixel channel open while a word is in flight");

endmodule

// ===== sim/tb_exact_color_palette_builder_unit.sv =====
`timescale 1ns / 1ps

module tb_exact_color_palette_builder_unit;
    import epb_pkg::*;

    localparam int RANDOM_PIXELS = 1080;
    localparam int STUCK_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 600;
    localparam int DRAIN_CYCLES  = 16;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        t_idx   idx;
        logic   fresh;
        t_color color;
        logic   ovf;
        logic   done;
    } t_pix_res;

    typedef struct packed {
        t_color   color;
        t_color   step;
        int       rep;
        logic     last;
        logic     typed;
        t_pix_res want;
    } t_stim_row;

    localparam int PLAN_ROWS = 17;
    localparam t_stim_row PLAN [PLAN_ROWS] = '{
        '{32'h0000_0000, 32'h0, 1, 1'b0, 1'b1, '{8'd0,   1'b1, 32'h0000_0000, 1'b0, 1'b0}},
        '{32'hFFFF_FFFF, 32'h0, 1, 1'b0, 1'b1, '{8'd1,   1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0}},
        '{32'h0000_0000, 32'h0, 1, 1'b0, 1'b1, '{8'd0,   1'b0, 32'h0000_0000, 1'b0, 1'b0}},
        '{32'hFFFF_FFFF, 32'h0, 1, 1'b0, 1'b1, '{8'd1,   1'b0, 32'h0000_0000, 1'b0, 1'b0}},
        '{32'h8000_0000, 32'h0, 1, 1'b0, 1'b1, '{8'd2,   1'b1, 32'h8000_0000, 1'b0, 1'b0}},
        '{32'h7FFF_FFFF, 32'h0, 1, 1'b0, 1'b1, '{8'd3,   1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0}},
        '{32'h5555_5555, 32'h0, 1, 1'b0, 1'b1, '{8'd4,   1'b1, 32'h5555_5555, 1'b0, 1'b0}},
        '{32'hAAAA_AAAA, 32'h0, 1, 1'b1, 1'b1, '{8'd5,   1'b1, 32'hAAAA_AAAA, 1'b0, 1'b1}},
        '{32'hAAAA_AAAA, 32'h0, 1, 1'b1, 1'b1, '{8'd0,   1'b1, 32'hAAAA_AAAA, 1'b0, 1'b1}},
        '{32'h8000_0000, 32'hFFFF_FFFF, 128, 1'b0, 1'b0, '0},
        '{32'h0000_0001, 32'h0101_0101, 128, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'h0, 1, 1'b0, 1'b1, '{8'd0,   1'b0, 32'h0000_0000, 1'b1, 1'b0}},
        '{32'h7FFF_FFFF, 32'h0, 1, 1'b0, 1'b1, '{8'd1,   1'b0, 32'h0000_0000, 1'b1, 1'b0}},
        '{32'h0000_0001, 32'h0, 1, 1'b0, 1'b1, '{8'd128, 1'b0, 32'h0000_0000, 1'b1, 1'b0}},
        '{32'h1234_5678, 32'h0, 1, 1'b1, 1'b1, '{8'd0,   1'b0, 32'h0000_0000, 1'b1, 1'b1}},
        '{32'h1234_5678, 32'h0, 1, 1'b0, 1'b1, '{8'd0,   1'b1, 32'h1234_5678, 1'b0, 1'b0}},
        '{32'hFFFF_FFFF, 32'h0, 1, 1'b1, 1'b1, '{8'd1,   1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1}}
    };

    logic         i_clk;
    logic         i_rst_n;
    logic         i_valid;
    logic         o_stall;
    logic [31:0]  i_pixel_color;
    logic         i_last_pixel;
    logic         o_valid;
    logic         i_stall;
    logic [7:0]   o_palette_index;
    logic         o_new_entry;
    logic [31:0]  o_entry_color;
    logic         o_overflow;
    logic         o_image_done;

    t_color       pal_colors [PALETTE_ENTRIES];
    t_idx         pal_slots  [PALETTE_ENTRIES];
    int           pal_count = 0;
    logic         pal_ovf   = 1'b0;

    t_pix_res     palette_results_q [$];
    int           pixels_sent  = 0;
    int           results_seen = 0;
    int           err_cnt      = 0;
    int           stuck        = 0;

    exact_color_palette_builder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_pixel_color   (i_pixel_color),
        .i_last_pixel    (i_last_pixel),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_palette_index (o_palette_index),
        .o_new_entry     (o_new_entry),
        .o_entry_color   (o_entry_color),
        .o_overflow      (o_overflow),
        .o_image_done    (o_image_done)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_pix_res palette_assign(t_color color, logic last);
        t_pix_res r;
        int       pos;
        int       n;
        int       k;
        r   = '0;
        n   = pal_count;
        pos = 0;
        while (pos < n && pal_colors[pos] < color) pos++;
        if (pos < n && pal_colors[pos] == color) begin
            r.idx = pal_slots[pos];
        end else if (n >= PALETTE_ENTRIES) begin
            pal_ovf = 1'b1;
        end else begin
            for (k = n; k > pos; k--) begin
                pal_colors[k] = pal_colors[k-1];
                pal_slots[k]  = pal_slots[k-1];
            end
            pal_colors[pos] = color;
            pal_slots[pos]  = t_idx'(n);
            r.idx           = t_idx'(n);
            r.fresh         = 1'b1;
            r.color         = color;
            pal_count       = n + 1;
        end
        r.ovf  = pal_ovf;
        r.done = last;
        if (last) begin
            pal_count = 0;
            pal_ovf   = 1'b0;
        end
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_pixel(t_color color, logic last, logic typed, t_pix_res want,
                              logic calm);
        int       n;
        t_pix_res res;
        n = calm ? 0 : gap_len();
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pixel_color <= color;
        i_last_pixel  <= last;
        do @(posedge i_clk); while (o_stall);
        res = palette_assign(color, last);
        palette_results_q.push_back(typed ? want : res);
        pixels_sent++;
    endtask

    task automatic send_image();
        t_color pool [$];
        t_color base;
        t_color stride;
        t_color color;
        int     kind;
        int     pool_n;
        int     len;
        int     k;
        int     r;
        logic   calm;
        kind = $urandom_range(0, 9);
        calm = ($urandom_range(0, 3) == 0);
        base = $urandom();
        if (kind == 0) begin
            pool_n = $urandom_range(257, 272);
            len    = pool_n + $urandom_range(1, 32);
        end else if (kind == 1) begin
            pool_n = PALETTE_ENTRIES;
            len    = pool_n + $urandom_range(0, 40);
        end else if (kind == 2) begin
            pool_n = $urandom_range(17, 255);
            len    = $urandom_range(1, 300);
        end else begin
            pool_n = $urandom_range(1, 16);
            len    = $urandom_range(1, 40);
        end
        stride = $urandom() | 32'h1;
        for (k = 0; k < pool_n; k++) begin
            r = $urandom_range(0, 7);
            if (kind <= 1)   pool.push_back(base + t_color'(k) * stride);
            else if (r == 0) pool.push_back(base + t_color'(k));
            else if (r == 1) pool.push_back($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
            else if (r == 2) pool.push_back(base ^ (32'h1 << $urandom_range(0, 31)));
            else             pool.push_back($urandom());
        end
        for (k = 0; k < len; k++) begin
            if (kind <= 1 && k < pool_n)          color = pool[k];
            else if ($urandom_range(0, 15) == 0)  color = $urandom();
            else                                  color = pool[$urandom_range(0, pool_n - 1)];
            push_pixel(color, k == len - 1, 1'b0, '0, calm);
        end
    endtask

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
        end
    end

    initial begin
        wait (stuck >= STUCK_LIMIT);
        $display("FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        t_pix_res w;
        t_pix_res got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_palette_index, o_new_entry, o_entry_color, o_overflow, o_image_done};
            results_seen++;
            if (palette_results_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("unexpected word %0d: idx %0d new %b color %h ovf %b done %b",
                             results_seen, got.idx, got.fresh, got.color, got.ovf, got.done);
            end else begin
                w = palette_results_q.pop_front();
                if (got.idx !== w.idx || got.fresh !== w.fresh || got.color !== w.color ||
                    got.ovf !== w.ovf || got.done !== w.done) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS) begin
                        $display("mismatch on word %0d", results_seen);
                        $display("  want idx %0d new %b color %h ovf %b done %b",
                                 w.idx, w.fresh, w.color, w.ovf, w.done);
                        $display("  got  idx %0d new %b color %h ovf %b done %b",
                                 got.idx, got.fresh, got.color, got.ovf, got.done);
                    end
                end
            end
        end
    end

    initial begin
        int   n;
        int   m;
        logic held;
        held = 1'b0;
        i_stall <= 1'b0;
        repeat (6) @(posedge i_clk);
        forever begin
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                n    = HOLD_CYCLES;
            end else if ($urandom_range(0, 9) == 0) begin
                n = 0;
            end else begin
                n = gap_len();
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            m = (n == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
            repeat (m) @(posedge i_clk);
        end
    end

    initial begin
        int     row;
        int     j;
        int     start;
        t_color color;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_pixel_color <= '0;
        i_last_pixel  <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (row = 0; row < PLAN_ROWS; row++) begin
            color = PLAN[row].color;
            for (j = 0; j < PLAN[row].rep; j++) begin
                push_pixel(color, PLAN[row].last && (j == PLAN[row].rep - 1),
                           PLAN[row].typed, PLAN[row].want, 1'b0);
                color = color + PLAN[row].step;
            end
        end

        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS) send_image();
        i_valid <= 1'b0;

        while (palette_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
